[hdl/mtep_pkg.sv]
package mtep_pkg;

    // Input transfer: one track byte plus the track restart flag
    typedef struct packed {
        logic [7:0] byte_in;
        logic       track_start;
    } in_item_t;

    // Output transfer: one decoded event, header, payload byte or error
    typedef struct packed {
        logic [2:0]  kind;
        logic [27:0] delta_time;
        logic [7:0]  status;
        logic [6:0]  data_first;
        logic [6:0]  data_second;
        logic [7:0]  meta_type;
        logic [39:0] value;
        logic [7:0]  payload_byte;
        logic        last;
        logic [2:0]  error_code;
    } out_item_t;

    // Result of one parsing step
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } result_t;

    // Parser phase
    typedef enum logic [3:0] {
        PH_DELTA   = 4'd0,
        PH_STATUS  = 4'd1,
        PH_DATA1   = 4'd2,
        PH_DATA2   = 4'd3,
        PH_SYSLEN  = 4'd4,
        PH_MTYPE   = 4'd5,
        PH_MLEN    = 4'd6,
        PH_PAYLOAD = 4'd7,
        PH_MDATA   = 4'd8
    } phase_t;

    // Result kinds
    localparam logic [2:0] KIND_CHANNEL    = 3'd0;
    localparam logic [2:0] KIND_SYSEX      = 3'd1;
    localparam logic [2:0] KIND_META_FIXED = 3'd2;
    localparam logic [2:0] KIND_META_RAW   = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD    = 3'd4;
    localparam logic [2:0] KIND_ERROR      = 3'd5;

    // Error codes
    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_NO_RUNNING    = 3'd1;
    localparam logic [2:0] ERR_UNEXPECTED    = 3'd2;
    localparam logic [2:0] ERR_TOO_SHORT     = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN       = 3'd4;
    localparam logic [2:0] ERR_QUANTITY_LONG = 3'd5;

    // Status bytes
    localparam logic [7:0] STATUS_SYSTEM     = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX      = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_ESC  = 8'hF7;
    localparam logic [7:0] STATUS_META       = 8'hFF;
    localparam logic [3:0] NIB_PROGRAM       = 4'hC;
    localparam logic [3:0] NIB_PRESSURE      = 4'hD;

    // Meta types with a fixed layout
    localparam logic [7:0] META_SEQ_NUMBER   = 8'h00;
    localparam logic [7:0] META_CHAN_PREFIX  = 8'h20;
    localparam logic [7:0] META_PORT_PREFIX  = 8'h21;
    localparam logic [7:0] META_END_OF_TRACK = 8'h2F;
    localparam logic [7:0] META_TEMPO        = 8'h51;
    localparam logic [7:0] META_SMPTE        = 8'h54;
    localparam logic [7:0] META_TIME_SIG     = 8'h58;
    localparam logic [7:0] META_KEY_SIG      = 8'h59;

    typedef struct packed {
        logic       fixed;
        logic [2:0] need;
    } meta_layout_t;

    // Look up the byte count of a fixed meta layout
    function automatic meta_layout_t meta_layout(input logic [7:0] meta_type);
        meta_layout_t layout;
        layout.fixed = 1'b1;
        case (meta_type)
            META_SEQ_NUMBER:   layout.need = 3'd2;
            META_CHAN_PREFIX:  layout.need = 3'd1;
            META_PORT_PREFIX:  layout.need = 3'd1;
            META_END_OF_TRACK: layout.need = 3'd0;
            META_TEMPO:        layout.need = 3'd3;
            META_SMPTE:        layout.need = 3'd5;
            META_TIME_SIG:     layout.need = 3'd4;
            META_KEY_SIG:      layout.need = 3'd2;
            default:
            begin
                layout.fixed = 1'b0;
                layout.need  = 3'd0;
            end
        endcase
        return layout;
    endfunction

    // Program change and channel pressure carry one data byte
    function automatic logic one_data_byte(input logic [7:0] st);
        return (st[7:4] == NIB_PROGRAM) || (st[7:4] == NIB_PRESSURE);
    endfunction

endpackage

[hdl/midi_track_event_parser.sv]
// Standard MIDI file track event parser.
// Byte channel (byte_valid/byte_ready/byte_item): one track byte per transfer,
// with track_start set on the first byte of a track to clear running status
// and the parser phase. Event channel (event_valid/event_ready/event_item):
// at most one result per byte: channel message, sysex or raw meta header,
// packed fixed meta event, payload byte or error.
// A byte accepted into the byte register is parsed from there, and its
// result, if any, is presented from the result register.
// Throughput: one byte per cycle while results are taken; the parse is a
// single pass of logic between the byte register and the result register.
// Reset clears the phase to delta time, running status and all context,
// and empties both registers.
// When the receiver stalls, the result is held and the byte register still
// fills once; byte_ready then drops until the result is transferred.

module midi_track_event_parser #(
    parameter int MAX_QUANTITY_BYTES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  mtep_pkg::in_item_t  byte_item,
    output logic                event_valid,
    input  logic                event_ready,
    output mtep_pkg::out_item_t event_item
);

    logic                s1_valid_reg, s1_valid_next;
    mtep_pkg::in_item_t  s1_item_reg;
    logic                out_valid_reg, out_valid_next;
    mtep_pkg::out_item_t out_item_reg;
    logic                out_free;
    logic                take;
    mtep_pkg::result_t   result;

    // Handshake between the byte register and the result register
    assign out_free   = !out_valid_reg || event_ready;
    assign take       = s1_valid_reg && out_free;
    assign byte_ready = !s1_valid_reg || take;

    assign s1_valid_next  = (byte_valid && byte_ready) ? 1'b1 :
                            (take ? 1'b0 : s1_valid_reg);
    assign out_valid_next = (take && result.valid) ? 1'b1 :
                            (event_ready ? 1'b0 : out_valid_reg);

    mtep_parser #(
        .MAX_QUANTITY_BYTES(MAX_QUANTITY_BYTES)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (s1_item_reg),
        .result (result)
    );

    // Hold the incoming byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
            s1_item_reg <= byte_item;
    end

    // Hold the result until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && result.valid)
            out_item_reg <= result.item;
    end

    assign event_valid = out_valid_reg;
    assign event_item  = out_item_reg;

    // Check result consistency and stall behavior
    a_error_code : assert property (@(posedge clk) disable iff (!rst_n)
        event_valid |->
            ((event_item.kind == mtep_pkg::KIND_ERROR) ==
             (event_item.error_code != mtep_pkg::ERR_NONE)))
        else $error("error code does not match result kind");

    a_last_kind : assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && event_item.last) |->
            (event_item.kind == mtep_pkg::KIND_SYSEX ||
             event_item.kind == mtep_pkg::KIND_META_RAW ||
             event_item.kind == mtep_pkg::KIND_PAYLOAD))
        else $error("last flag on a result without payload");

    a_data_kind : assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && event_item.kind != mtep_pkg::KIND_CHANNEL) |->
            (event_item.data_first == 7'd0 && event_item.data_second == 7'd0))
        else $error("data bytes on a non-channel result");

    a_ready_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> (s1_valid_reg && out_valid_reg && !event_ready))
        else $error("byte channel stalled without a stalled result");

endmodule

[hdl/mtep_parser.sv]
module mtep_parser #(
    parameter int MAX_QUANTITY_BYTES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  mtep_pkg::in_item_t  item,
    output mtep_pkg::result_t   result
);

    localparam int QW = 7 * MAX_QUANTITY_BYTES;
    localparam int CW = $clog2(MAX_QUANTITY_BYTES + 1);

    mtep_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [7:0]  running_reg, running_next, running_eff;
    logic [7:0]  current_reg, current_next;
    logic [QW-1:0] acc_reg, acc_next, acc_eff;
    logic [CW-1:0] cnt_reg, cnt_next, cnt_eff;
    logic [QW-1:0] delta_reg, delta_next;
    logic [6:0]  held_data_reg, held_data_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [QW-1:0] remain_reg, remain_next;
    logic [39:0] packed_reg, packed_next;
    logic [2:0]  seen_reg, seen_next;

    logic [7:0]    b;
    logic [QW-1:0] q_acc;
    logic [CW-1:0] q_cnt;
    logic          q_done;
    logic          q_long;
    logic [QW-1:0] remain_dec;
    logic          len_short;
    logic [2:0]    fail_code;
    mtep_pkg::meta_layout_t layout;

    // Apply a track restart before the byte is parsed
    assign b           = item.byte_in;
    assign phase_eff   = item.track_start ? mtep_pkg::PH_DELTA : phase_reg;
    assign running_eff = item.track_start ? 8'd0 : running_reg;
    assign acc_eff     = item.track_start ? '0 : acc_reg;
    assign cnt_eff     = item.track_start ? '0 : cnt_reg;

    // Shift one quantity byte in and check for overlong quantities
    assign q_acc      = QW'({acc_eff, b[6:0]});
    assign q_cnt      = cnt_eff + CW'(1);
    assign q_done     = !b[7];
    assign q_long     = b[7] && (q_cnt >= CW'(MAX_QUANTITY_BYTES));
    assign remain_dec = remain_reg - QW'(1);
    assign layout     = mtep_pkg::meta_layout(held_type_reg);
    assign len_short  = q_acc < QW'(layout.need);

    // Next phase
    always_comb
    begin
        phase_next = phase_eff;
        case (phase_eff)
            mtep_pkg::PH_STATUS:
            begin
                if (b[7])
                begin
                    if (b < mtep_pkg::STATUS_SYSTEM)
                        phase_next = mtep_pkg::PH_DATA1;
                    else if (b == mtep_pkg::STATUS_SYSEX || b == mtep_pkg::STATUS_SYSEX_ESC)
                        phase_next = mtep_pkg::PH_SYSLEN;
                    else if (b == mtep_pkg::STATUS_META)
                        phase_next = mtep_pkg::PH_MTYPE;
                    else
                        phase_next = mtep_pkg::PH_DELTA;
                end
                else if (!running_eff[7] || mtep_pkg::one_data_byte(running_eff))
                    phase_next = mtep_pkg::PH_DELTA;
                else
                    phase_next = mtep_pkg::PH_DATA2;
            end
            mtep_pkg::PH_DATA1:
            begin
                if (b[7] || mtep_pkg::one_data_byte(current_reg))
                    phase_next = mtep_pkg::PH_DELTA;
                else
                    phase_next = mtep_pkg::PH_DATA2;
            end
            mtep_pkg::PH_DATA2:
                phase_next = mtep_pkg::PH_DELTA;
            mtep_pkg::PH_SYSLEN:
            begin
                if (q_done)
                    phase_next = (q_acc != '0) ? mtep_pkg::PH_PAYLOAD : mtep_pkg::PH_DELTA;
                else if (q_long)
                    phase_next = mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_MTYPE:
                phase_next = mtep_pkg::PH_MLEN;
            mtep_pkg::PH_MLEN:
            begin
                if (q_done)
                begin
                    if (!layout.fixed)
                        phase_next = (q_acc != '0) ? mtep_pkg::PH_PAYLOAD : mtep_pkg::PH_DELTA;
                    else if (len_short || q_acc == '0)
                        phase_next = mtep_pkg::PH_DELTA;
                    else
                        phase_next = mtep_pkg::PH_MDATA;
                end
                else if (q_long)
                    phase_next = mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_PAYLOAD, mtep_pkg::PH_MDATA:
            begin
                if (remain_dec == '0)
                    phase_next = mtep_pkg::PH_DELTA;
            end
            default:
            begin
                if (q_done)
                    phase_next = mtep_pkg::PH_STATUS;
                else
                    phase_next = mtep_pkg::PH_DELTA;
            end
        endcase
    end

    // Context registers and result
    always_comb
    begin
        running_next   = running_eff;
        current_next   = current_reg;
        acc_next       = acc_eff;
        cnt_next       = cnt_eff;
        delta_next     = delta_reg;
        held_data_next = held_data_reg;
        held_type_next = held_type_reg;
        remain_next    = remain_reg;
        packed_next    = packed_reg;
        seen_next      = seen_reg;
        fail_code      = mtep_pkg::ERR_NONE;
        result         = '0;

        case (phase_eff)
            mtep_pkg::PH_STATUS:
            begin
                if (b[7])
                begin
                    current_next = b;
                    if (b == mtep_pkg::STATUS_SYSEX || b == mtep_pkg::STATUS_SYSEX_ESC)
                    begin
                        acc_next = '0;
                        cnt_next = '0;
                    end
                    else if (b >= mtep_pkg::STATUS_SYSTEM && b != mtep_pkg::STATUS_META)
                        fail_code = mtep_pkg::ERR_UNKNOWN;
                end
                else if (!running_eff[7])
                begin
                    current_next = 8'd0;
                    fail_code    = mtep_pkg::ERR_NO_RUNNING;
                end
                else
                begin
                    current_next = running_eff;
                    if (mtep_pkg::one_data_byte(running_eff))
                    begin
                        result.valid                 = 1'b1;
                        result.item.kind             = mtep_pkg::KIND_CHANNEL;
                        result.item.delta_time       = 28'(delta_reg);
                        result.item.status           = running_eff;
                        result.item.data_first       = b[6:0];
                    end
                    else
                        held_data_next = b[6:0];
                end
            end
            mtep_pkg::PH_DATA1:
            begin
                if (b[7])
                    fail_code = mtep_pkg::ERR_UNEXPECTED;
                else if (mtep_pkg::one_data_byte(current_reg))
                begin
                    running_next           = current_reg;
                    result.valid           = 1'b1;
                    result.item.kind       = mtep_pkg::KIND_CHANNEL;
                    result.item.delta_time = 28'(delta_reg);
                    result.item.status     = current_reg;
                    result.item.data_first = b[6:0];
                end
                else
                    held_data_next = b[6:0];
            end
            mtep_pkg::PH_DATA2:
            begin
                if (b[7])
                    fail_code = mtep_pkg::ERR_UNEXPECTED;
                else
                begin
                    running_next            = current_reg;
                    result.valid            = 1'b1;
                    result.item.kind        = mtep_pkg::KIND_CHANNEL;
                    result.item.delta_time  = 28'(delta_reg);
                    result.item.status      = current_reg;
                    result.item.data_first  = held_data_reg;
                    result.item.data_second = b[6:0];
                end
            end
            mtep_pkg::PH_SYSLEN:
            begin
                acc_next = q_acc;
                cnt_next = q_cnt;
                if (q_done)
                begin
                    acc_next               = '0;
                    cnt_next               = '0;
                    remain_next            = q_acc;
                    held_type_next         = 8'd0;
                    result.valid           = 1'b1;
                    result.item.kind       = mtep_pkg::KIND_SYSEX;
                    result.item.delta_time = 28'(delta_reg);
                    result.item.status     = current_reg;
                    result.item.value      = 40'(q_acc);
                    result.item.last       = (q_acc == '0);
                end
                else if (q_long)
                    fail_code = mtep_pkg::ERR_QUANTITY_LONG;
            end
            mtep_pkg::PH_MTYPE:
            begin
                held_type_next = b;
                acc_next       = '0;
                cnt_next       = '0;
            end
            mtep_pkg::PH_MLEN:
            begin
                acc_next = q_acc;
                cnt_next = q_cnt;
                if (q_done)
                begin
                    acc_next    = '0;
                    cnt_next    = '0;
                    remain_next = q_acc;
                    if (!layout.fixed)
                    begin
                        result.valid           = 1'b1;
                        result.item.kind       = mtep_pkg::KIND_META_RAW;
                        result.item.delta_time = 28'(delta_reg);
                        result.item.status     = current_reg;
                        result.item.meta_type  = held_type_reg;
                        result.item.value      = 40'(q_acc);
                        result.item.last       = (q_acc == '0);
                    end
                    else if (len_short)
                        fail_code = mtep_pkg::ERR_TOO_SHORT;
                    else
                    begin
                        packed_next = 40'd0;
                        seen_next   = 3'd0;
                        if (q_acc == '0)
                        begin
                            result.valid           = 1'b1;
                            result.item.kind       = mtep_pkg::KIND_META_FIXED;
                            result.item.delta_time = 28'(delta_reg);
                            result.item.status     = current_reg;
                            result.item.meta_type  = held_type_reg;
                        end
                    end
                end
                else if (q_long)
                    fail_code = mtep_pkg::ERR_QUANTITY_LONG;
            end
            mtep_pkg::PH_PAYLOAD:
            begin
                remain_next              = remain_dec;
                result.valid             = 1'b1;
                result.item.kind         = mtep_pkg::KIND_PAYLOAD;
                result.item.delta_time   = 28'(delta_reg);
                result.item.status       = current_reg;
                result.item.meta_type    = held_type_reg;
                result.item.payload_byte = b;
                result.item.last         = (remain_dec == '0);
            end
            mtep_pkg::PH_MDATA:
            begin
                // Keep only the bytes of the layout, drop the rest
                if (seen_reg < layout.need)
                begin
                    packed_next = {packed_reg[31:0], b};
                    seen_next   = seen_reg + 3'd1;
                end
                remain_next = remain_dec;
                if (remain_dec == '0)
                begin
                    result.valid           = 1'b1;
                    result.item.kind       = mtep_pkg::KIND_META_FIXED;
                    result.item.delta_time = 28'(delta_reg);
                    result.item.status     = current_reg;
                    result.item.meta_type  = held_type_reg;
                    result.item.value      = packed_next;
                end
            end
            default:
            begin
                acc_next = q_acc;
                cnt_next = q_cnt;
                if (q_done)
                begin
                    delta_next = q_acc;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
                else if (q_long)
                begin
                    delta_next   = '0;
                    current_next = 8'd0;
                    fail_code    = mtep_pkg::ERR_QUANTITY_LONG;
                end
            end
        endcase

        // Report the error and drop the partial quantity
        if (fail_code != mtep_pkg::ERR_NONE)
        begin
            acc_next               = '0;
            cnt_next               = '0;
            result                 = '0;
            result.valid           = 1'b1;
            result.item.kind       = mtep_pkg::KIND_ERROR;
            result.item.delta_time = 28'(delta_next);
            result.item.status     = current_next;
            result.item.error_code = fail_code;
        end
    end

    // Advance the parser state on each taken byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mtep_pkg::PH_DELTA;
            running_reg   <= 8'd0;
            current_reg   <= 8'd0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            delta_reg     <= '0;
            held_data_reg <= 7'd0;
            held_type_reg <= 8'd0;
            remain_reg    <= '0;
            packed_reg    <= 40'd0;
            seen_reg      <= 3'd0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            running_reg   <= running_next;
            current_reg   <= current_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            delta_reg     <= delta_next;
            held_data_reg <= held_data_next;
            held_type_reg <= held_type_next;
            remain_reg    <= remain_next;
            packed_reg    <= packed_next;
            seen_reg      <= seen_next;
        end
    end

endmodule

[verif/tb_midi_track_event_parser.sv]
module tb_midi_track_event_parser;

    localparam int QTY_BYTES_MAX = 4;
    localparam int STIM_BYTES    = 800;
    localparam int IDLE_PCT      = 31;
    localparam int STALL_LIMIT   = 2000;
    localparam int CALM_FIRST    = 300;
    localparam int CALM_LAST     = 450;

    // Outcome of feeding one byte into a variable-length quantity
    typedef enum logic [1:0] {
        QTY_MORE,
        QTY_DONE,
        QTY_LONG
    } qty_step_t;

    // Track parser prediction plus comparison of decoded events
    class event_scoreboard;
        mtep_pkg::phase_t    step_phase;
        logic [7:0]          running_st;
        logic [7:0]          active_st;
        logic [27:0]         qty_value;
        int                  qty_count;
        logic [27:0]         event_dt;
        logic [6:0]          first_data;
        logic [7:0]          meta_code;
        logic [27:0]         left_bytes;
        logic [39:0]         meta_value;
        int                  meta_taken;
        mtep_pkg::out_item_t pending_events[$];
        int                  mismatches;
        int                  results_seen;
        int                  kind_hits[8];

        function new();
            step_phase = mtep_pkg::PH_DELTA;
            running_st = '0;
            active_st  = '0;
            qty_value  = '0;
            qty_count  = 0;
            event_dt   = '0;
            first_data = '0;
            meta_code  = '0;
            left_bytes = '0;
            meta_value = '0;
            meta_taken = 0;
            mismatches = 0;
            results_seen = 0;
        endfunction

        // Bytes a fixed meta layout carries, -1 for a pass-through meta
        function int layout_len(logic [7:0] mtype);
            case (mtype)
                mtep_pkg::META_SEQ_NUMBER:   return 2;
                mtep_pkg::META_CHAN_PREFIX:  return 1;
                mtep_pkg::META_PORT_PREFIX:  return 1;
                mtep_pkg::META_END_OF_TRACK: return 0;
                mtep_pkg::META_TEMPO:        return 3;
                mtep_pkg::META_SMPTE:        return 5;
                mtep_pkg::META_TIME_SIG:     return 4;
                mtep_pkg::META_KEY_SIG:      return 2;
                default:                     return -1;
            endcase
        endfunction

        function bit carries_one_byte(logic [7:0] st);
            return st[7:4] == mtep_pkg::NIB_PROGRAM || st[7:4] == mtep_pkg::NIB_PRESSURE;
        endfunction

        function void clear_qty();
            qty_value = '0;
            qty_count = 0;
        endfunction

        // Shift seven more bits into the quantity
        function qty_step_t take_qty(logic [7:0] b);
            qty_value = {qty_value[20:0], b[6:0]};
            qty_count++;
            if (!b[7])
                return QTY_DONE;
            if (qty_count >= QTY_BYTES_MAX)
                return QTY_LONG;
            return QTY_MORE;
        endfunction

        function mtep_pkg::out_item_t make_event(logic [2:0] kind);
            mtep_pkg::out_item_t e;
            e = '0;
            e.kind       = kind;
            e.delta_time = event_dt;
            e.status     = active_st;
            return e;
        endfunction

        // Flag an error and fall back to the delta-time phase
        function void raise_error(logic [2:0] code);
            mtep_pkg::out_item_t e;
            e = make_event(mtep_pkg::KIND_ERROR);
            e.error_code = code;
            pending_events.push_back(e);
            step_phase = mtep_pkg::PH_DELTA;
            clear_qty();
        endfunction

        // Advance the parser by one accepted byte
        function void note_byte(mtep_pkg::in_item_t it);
            logic [7:0]          b;
            mtep_pkg::out_item_t e;
            qty_step_t           q;
            int                  need;
            b = it.byte_in;
            if (it.track_start)
            begin
                running_st = '0;
                step_phase = mtep_pkg::PH_DELTA;
                clear_qty();
            end
            case (step_phase)
                mtep_pkg::PH_STATUS:
                begin
                    if (b[7])
                    begin
                        active_st = b;
                        if (b < mtep_pkg::STATUS_SYSTEM)
                            step_phase = mtep_pkg::PH_DATA1;
                        else if (b == mtep_pkg::STATUS_SYSEX || b == mtep_pkg::STATUS_SYSEX_ESC)
                        begin
                            step_phase = mtep_pkg::PH_SYSLEN;
                            clear_qty();
                        end
                        else if (b == mtep_pkg::STATUS_META)
                            step_phase = mtep_pkg::PH_MTYPE;
                        else
                            raise_error(mtep_pkg::ERR_UNKNOWN);
                    end
                    else if (!running_st[7])
                    begin
                        active_st = '0;
                        raise_error(mtep_pkg::ERR_NO_RUNNING);
                    end
                    else
                    begin
                        active_st = running_st;
                        if (carries_one_byte(active_st))
                        begin
                            e = make_event(mtep_pkg::KIND_CHANNEL);
                            e.data_first = b[6:0];
                            pending_events.push_back(e);
                            step_phase = mtep_pkg::PH_DELTA;
                        end
                        else
                        begin
                            first_data = b[6:0];
                            step_phase = mtep_pkg::PH_DATA2;
                        end
                    end
                end
                mtep_pkg::PH_DATA1:
                begin
                    if (b[7])
                        raise_error(mtep_pkg::ERR_UNEXPECTED);
                    else if (carries_one_byte(active_st))
                    begin
                        running_st = active_st;
                        e = make_event(mtep_pkg::KIND_CHANNEL);
                        e.data_first = b[6:0];
                        pending_events.push_back(e);
                        step_phase = mtep_pkg::PH_DELTA;
                    end
                    else
                    begin
                        first_data = b[6:0];
                        step_phase = mtep_pkg::PH_DATA2;
                    end
                end
                mtep_pkg::PH_DATA2:
                begin
                    if (b[7])
                        raise_error(mtep_pkg::ERR_UNEXPECTED);
                    else
                    begin
                        running_st = active_st;
                        e = make_event(mtep_pkg::KIND_CHANNEL);
                        e.data_first  = first_data;
                        e.data_second = b[6:0];
                        pending_events.push_back(e);
                        step_phase = mtep_pkg::PH_DELTA;
                    end
                end
                mtep_pkg::PH_SYSLEN:
                begin
                    q = take_qty(b);
                    if (q == QTY_LONG)
                        raise_error(mtep_pkg::ERR_QUANTITY_LONG);
                    else if (q == QTY_DONE)
                    begin
                        left_bytes = qty_value;
                        clear_qty();
                        meta_code = '0;
                        e = make_event(mtep_pkg::KIND_SYSEX);
                        e.value = 40'(left_bytes);
                        e.last  = left_bytes == 0;
                        pending_events.push_back(e);
                        step_phase = (left_bytes != 0) ? mtep_pkg::PH_PAYLOAD : mtep_pkg::PH_DELTA;
                    end
                end
                mtep_pkg::PH_MTYPE:
                begin
                    meta_code = b;
                    clear_qty();
                    step_phase = mtep_pkg::PH_MLEN;
                end
                mtep_pkg::PH_MLEN:
                begin
                    q = take_qty(b);
                    if (q == QTY_LONG)
                        raise_error(mtep_pkg::ERR_QUANTITY_LONG);
                    else if (q == QTY_DONE)
                    begin
                        left_bytes = qty_value;
                        clear_qty();
                        need = layout_len(meta_code);
                        if (need < 0)
                        begin
                            e = make_event(mtep_pkg::KIND_META_RAW);
                            e.meta_type = meta_code;
                            e.value     = 40'(left_bytes);
                            e.last      = left_bytes == 0;
                            pending_events.push_back(e);
                            step_phase = (left_bytes != 0) ? mtep_pkg::PH_PAYLOAD :
                                                             mtep_pkg::PH_DELTA;
                        end
                        else if (left_bytes < need)
                            raise_error(mtep_pkg::ERR_TOO_SHORT);
                        else
                        begin
                            meta_value = '0;
                            meta_taken = 0;
                            if (left_bytes == 0)
                            begin
                                e = make_event(mtep_pkg::KIND_META_FIXED);
                                e.meta_type = meta_code;
                                pending_events.push_back(e);
                                step_phase = mtep_pkg::PH_DELTA;
                            end
                            else
                                step_phase = mtep_pkg::PH_MDATA;
                        end
                    end
                end
                mtep_pkg::PH_PAYLOAD:
                begin
                    left_bytes = left_bytes - 28'd1;
                    e = make_event(mtep_pkg::KIND_PAYLOAD);
                    e.meta_type    = meta_code;
                    e.payload_byte = b;
                    e.last         = left_bytes == 0;
                    pending_events.push_back(e);
                    if (left_bytes == 0)
                        step_phase = mtep_pkg::PH_DELTA;
                end
                mtep_pkg::PH_MDATA:
                begin
                    // pack only what the layout needs, drop the rest
                    if (meta_taken < layout_len(meta_code))
                    begin
                        meta_value = {meta_value[31:0], b};
                        meta_taken++;
                    end
                    left_bytes = left_bytes - 28'd1;
                    if (left_bytes == 0)
                    begin
                        e = make_event(mtep_pkg::KIND_META_FIXED);
                        e.meta_type = meta_code;
                        e.value     = meta_value;
                        pending_events.push_back(e);
                        step_phase = mtep_pkg::PH_DELTA;
                    end
                end
                default:
                begin
                    step_phase = mtep_pkg::PH_DELTA;
                    q = take_qty(b);
                    if (q == QTY_LONG)
                    begin
                        event_dt  = '0;
                        active_st = '0;
                        raise_error(mtep_pkg::ERR_QUANTITY_LONG);
                    end
                    else if (q == QTY_DONE)
                    begin
                        event_dt = qty_value;
                        clear_qty();
                        step_phase = mtep_pkg::PH_STATUS;
                    end
                end
            endcase
        endfunction

        task report(string msg);
            mismatches++;
            $display("event check: %s", msg);
        endtask

        task field_check(string name, logic [39:0] got, logic [39:0] want);
            if (got !== want)
                report($sformatf("event %0d %s got 0x%0h, want 0x%0h",
                                 results_seen, name, got, want));
        endtask

        // Compare one transferred event with the oldest prediction
        task check_event(mtep_pkg::out_item_t got);
            mtep_pkg::out_item_t want;
            results_seen++;
            if (pending_events.size() == 0)
            begin
                report($sformatf("event %0d arrived with none predicted", results_seen));
                return;
            end
            want = pending_events.pop_front();
            kind_hits[want.kind]++;
            field_check("kind", 40'(got.kind), 40'(want.kind));
            field_check("delta_time", 40'(got.delta_time), 40'(want.delta_time));
            field_check("status", 40'(got.status), 40'(want.status));
            field_check("data_first", 40'(got.data_first), 40'(want.data_first));
            field_check("data_second", 40'(got.data_second), 40'(want.data_second));
            field_check("meta_type", 40'(got.meta_type), 40'(want.meta_type));
            field_check("value", got.value, want.value);
            field_check("payload_byte", 40'(got.payload_byte), 40'(want.payload_byte));
            field_check("last", 40'(got.last), 40'(want.last));
            field_check("error_code", 40'(got.error_code), 40'(want.error_code));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                byte_valid;
    logic                byte_ready;
    mtep_pkg::in_item_t  byte_item;
    logic                event_valid;
    logic                event_ready;
    mtep_pkg::out_item_t event_item;
    logic                calm;

    event_scoreboard    sb = new();
    mtep_pkg::in_item_t track_bytes[$];
    int                 drain_at[$];
    int                 drains_done;
    int                 stall_cycles;
    logic [7:0]         fixed_types[8] = '{
        mtep_pkg::META_SEQ_NUMBER, mtep_pkg::META_CHAN_PREFIX, mtep_pkg::META_PORT_PREFIX,
        mtep_pkg::META_END_OF_TRACK, mtep_pkg::META_TEMPO, mtep_pkg::META_SMPTE,
        mtep_pkg::META_TIME_SIG, mtep_pkg::META_KEY_SIG};

    midi_track_event_parser #(
        .MAX_QUANTITY_BYTES(QTY_BYTES_MAX)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_item   (byte_item),
        .event_valid (event_valid),
        .event_ready (event_ready),
        .event_item  (event_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void put_byte(logic [7:0] b, logic restart = 1'b0);
        mtep_pkg::in_item_t it;
        it.byte_in     = b;
        it.track_start = restart;
        track_bytes.push_back(it);
    endfunction

    // Encode a quantity, optionally with leading zero groups
    function automatic void put_quantity(logic [27:0] v, int pad, logic restart);
        int         groups;
        int         total;
        logic [7:0] b;
        groups = 1;
        while (groups < QTY_BYTES_MAX && (v >> (7 * groups)) != 0)
            groups++;
        total = (groups + pad > QTY_BYTES_MAX) ? QTY_BYTES_MAX : groups + pad;
        for (int i = total - 1; i >= 0; i--)
        begin
            b[6:0] = v[7 * i +: 7];
            b[7]   = i != 0;
            put_byte(b, restart && i == total - 1);
        end
    endfunction

    // Quantity that still continues after the last allowed byte
    function automatic void put_long_quantity(logic restart);
        for (int k = 0; k < QTY_BYTES_MAX; k++)
            put_byte({1'b1, 7'($urandom)}, restart && k == 0);
    endfunction

    function automatic void put_channel(logic restart, logic [27:0] dt, logic [7:0] st,
                                        logic with_status, logic [6:0] d1, logic [6:0] d2);
        put_quantity(dt, 0, restart);
        if (with_status)
            put_byte(st);
        put_byte({1'b0, d1});
        if (!sb.carries_one_byte(st))
            put_byte({1'b0, d2});
    endfunction

    function automatic void put_sysex(logic restart, logic [27:0] dt, logic [7:0] st,
                                      int len, int pad);
        put_quantity(dt, 0, restart);
        put_byte(st);
        put_quantity(28'(len), pad, 1'b0);
        repeat (len) put_byte(8'($urandom));
    endfunction

    function automatic void put_meta(logic restart, logic [27:0] dt, logic [7:0] mtype,
                                     int len, int pad);
        put_quantity(dt, 0, restart);
        put_byte(mtep_pkg::STATUS_META);
        put_byte(mtype);
        put_quantity(28'(len), pad, 1'b0);
        repeat (len) put_byte(8'($urandom));
    endfunction

    // Mostly short deltas, sometimes up to the full 28 bits
    function automatic logic [27:0] rand_delta();
        case ($urandom_range(0, 9))
            6, 7:    return 28'($urandom_range(0, 16383));
            8:       return 28'($urandom_range(0, 2097151));
            9:       return 28'($urandom);
            default: return 28'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic int rand_len();
        return ($urandom_range(0, 29) == 0) ? $urandom_range(128, 160) : $urandom_range(0, 6);
    endfunction

    // Hold the byte until the parser takes it, with random idle gaps
    task automatic send_byte(mtep_pkg::in_item_t it);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= it;
        do
            @(posedge clk);
        while (!byte_ready);
    endtask

    // Note byte transfers and check event transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
                sb.note_byte(byte_item);
            if (event_valid && event_ready)
                sb.check_event(event_item);
        end
    end

    // Stall the event side at random outside the calm stretch
    initial
    begin
        event_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            event_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // End the run when no transfer happens for too long
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (byte_valid && byte_ready) || (event_valid && event_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("midi_track_event_parser: mismatch");
        $finish;
    end

    initial
    begin
        logic       restart;
        logic       force_restart;
        logic       with_status;
        logic [7:0] stim_running;
        logic [7:0] st;
        logic [7:0] mtype;
        int         pick;
        int         need;
        int         len;

        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_item  <= '0;
        calm       <= 1'b0;
        drains_done = 0;

        // Directed: field extremes, every event kind, every error
        put_channel(1'b1, 28'h0, 8'h90, 1'b1, 7'h00, 7'h7F);
        put_channel(1'b0, 28'h7F, 8'h90, 1'b0, 7'h7F, 7'h00);
        put_channel(1'b0, 28'hFFFFFFF, 8'hC5, 1'b1, 7'h7F, 7'h00);
        put_channel(1'b0, 28'h0, 8'hC5, 1'b0, 7'h00, 7'h00);
        put_channel(1'b0, 28'h3FFF, 8'hDF, 1'b1, 7'h55, 7'h00);
        put_channel(1'b0, 28'h80, 8'hEF, 1'b1, 7'h7F, 7'h7F);
        put_sysex(1'b0, 28'h1FFFFF, mtep_pkg::STATUS_SYSEX, 3, 1);
        put_sysex(1'b0, 28'h5, mtep_pkg::STATUS_SYSEX_ESC, 0, 0);
        put_meta(1'b0, 28'h1, mtep_pkg::META_TEMPO, 3, 0);
        // running status must survive sysex and meta events
        put_channel(1'b0, 28'h0, 8'hEF, 1'b0, 7'h01, 7'h02);
        put_meta(1'b0, 28'h2, mtep_pkg::META_SMPTE, 5, 1);
        put_meta(1'b0, 28'h3, mtep_pkg::META_SEQ_NUMBER, 2, 0);
        put_meta(1'b0, 28'h4, mtep_pkg::META_CHAN_PREFIX, 1, 0);
        put_meta(1'b0, 28'h5, mtep_pkg::META_PORT_PREFIX, 1, 0);
        put_meta(1'b0, 28'h6, mtep_pkg::META_TIME_SIG, 4, 0);
        put_meta(1'b0, 28'h7, mtep_pkg::META_KEY_SIG, 2, 0);
        put_meta(1'b0, 28'h8, mtep_pkg::META_END_OF_TRACK, 0, 0);
        put_meta(1'b0, 28'h9, mtep_pkg::META_END_OF_TRACK, 2, 0);
        put_meta(1'b0, 28'hA, mtep_pkg::META_TEMPO, 5, 0);
        put_meta(1'b0, 28'hB, 8'h01, 4, 0);
        put_meta(1'b0, 28'hC, 8'h7F, 0, 0);
        put_meta(1'b0, 28'hD, mtep_pkg::META_CHAN_PREFIX, 0, 0);
        put_meta(1'b0, 28'hE, mtep_pkg::META_TEMPO, 2, 0);
        put_quantity(28'h0, 0, 1'b1);
        put_byte(8'h40);
        put_quantity(28'h12, 0, 1'b0);
        put_byte(8'h92);
        put_byte(mtep_pkg::STATUS_SYSEX);
        put_quantity(28'h13, 0, 1'b0);
        put_byte(8'hB1);
        put_byte(8'h07);
        put_byte(8'h80);
        put_quantity(28'h14, 0, 1'b0);
        put_byte(8'hF1);
        put_quantity(28'h15, 0, 1'b0);
        put_byte(8'hFE);
        put_long_quantity(1'b0);
        put_quantity(28'h16, 0, 1'b0);
        put_byte(mtep_pkg::STATUS_SYSEX);
        put_long_quantity(1'b0);
        put_quantity(28'h17, 0, 1'b0);
        put_byte(mtep_pkg::STATUS_META);
        put_byte(mtep_pkg::META_END_OF_TRACK);
        put_long_quantity(1'b0);
        drain_at.push_back(track_bytes.size());

        // Random: mostly well-formed events, the rest broken or noise
        stim_running  = '0;
        force_restart = 1'b1;
        while (track_bytes.size() < STIM_BYTES)
        begin
            restart       = force_restart || ($urandom_range(0, 24) == 0);
            force_restart = 1'b0;
            if (restart)
                stim_running = '0;
            if (drain_at.size() < 2 && track_bytes.size() >= STIM_BYTES / 2)
                drain_at.push_back(track_bytes.size());
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                with_status = stim_running == 0 || $urandom_range(0, 2) == 0;
                st = with_status ? 8'($urandom_range(8'h80, 8'hEF)) : stim_running;
                put_channel(restart, rand_delta(), st, with_status, 7'($urandom), 7'($urandom));
                stim_running = st;
            end
            else if (pick < 55)
                put_sysex(restart, rand_delta(),
                          $urandom_range(0, 1) ? mtep_pkg::STATUS_SYSEX :
                                                 mtep_pkg::STATUS_SYSEX_ESC,
                          rand_len(), int'($urandom_range(0, 3) == 0));
            else if (pick < 66)
            begin
                mtype = fixed_types[3'($urandom_range(0, 7))];
                need  = sb.layout_len(mtype);
                len   = ($urandom_range(0, 9) < 7) ? need : need + $urandom_range(1, 3);
                put_meta(restart, rand_delta(), mtype, len, int'($urandom_range(0, 3) == 0));
            end
            else if (pick < 74)
                put_meta(restart, rand_delta(), 8'($urandom), rand_len(),
                         int'($urandom_range(0, 3) == 0));
            else if (pick < 93)
            begin
                case ($urandom_range(0, 6))
                    0: put_long_quantity(restart);
                    1:
                    begin
                        put_quantity(rand_delta(), 0, 1'b1);
                        put_byte(8'($urandom_range(0, 127)));
                        stim_running = '0;
                    end
                    2:
                    begin
                        put_quantity(rand_delta(), 0, restart);
                        st = 8'($urandom_range(8'h80, 8'hEF));
                        put_byte(st);
                        if (!sb.carries_one_byte(st) && $urandom_range(0, 1))
                            put_byte(8'($urandom_range(0, 127)));
                        put_byte(8'($urandom_range(8'h80, 8'hFF)));
                    end
                    3:
                    begin
                        put_quantity(rand_delta(), 0, restart);
                        pick = $urandom_range(0, 12);
                        put_byte(8'((pick < 6) ? 8'hF1 + pick : 8'hF8 + pick - 6));
                    end
                    4:
                    begin
                        do
                            mtype = fixed_types[3'($urandom_range(0, 7))];
                        while (mtype == mtep_pkg::META_END_OF_TRACK);
                        put_meta(restart, rand_delta(), mtype,
                                 $urandom_range(0, sb.layout_len(mtype) - 1), 0);
                    end
                    5:
                    begin
                        put_quantity(rand_delta(), 0, restart);
                        put_byte($urandom_range(0, 1) ? mtep_pkg::STATUS_SYSEX :
                                                        mtep_pkg::STATUS_SYSEX_ESC);
                        put_long_quantity(1'b0);
                    end
                    default:
                    begin
                        put_quantity(rand_delta(), 0, restart);
                        put_byte(mtep_pkg::STATUS_META);
                        put_byte(8'($urandom));
                        put_long_quantity(1'b0);
                    end
                endcase
            end
            else
            begin
                // raw noise, then resync on a fresh track
                repeat ($urandom_range(1, 6))
                    put_byte(8'($urandom), $urandom_range(0, 7) == 0);
                force_restart = 1'b1;
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < track_bytes.size(); i++)
        begin
            // hold off the sender until every predicted event is out
            if (drain_at.size() != 0 && drain_at[0] == i)
            begin
                void'(drain_at.pop_front());
                byte_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending_events.size() != 0)
                    @(posedge clk);
                drains_done++;
            end
            calm <= (i >= CALM_FIRST && i < CALM_LAST);
            send_byte(track_bytes[i]);
        end
        byte_valid <= 1'b0;
        calm       <= 1'b0;

        while (sb.pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("sent %0d track bytes, checked %0d events, %0d drain pauses",
                 track_bytes.size(), sb.results_seen, drains_done);
        $display("kinds: channel %0d sysex %0d fixed %0d raw %0d payload %0d error %0d",
                 sb.kind_hits[mtep_pkg::KIND_CHANNEL], sb.kind_hits[mtep_pkg::KIND_SYSEX],
                 sb.kind_hits[mtep_pkg::KIND_META_FIXED], sb.kind_hits[mtep_pkg::KIND_META_RAW],
                 sb.kind_hits[mtep_pkg::KIND_PAYLOAD], sb.kind_hits[mtep_pkg::KIND_ERROR]);
        if (sb.mismatches == 0 && sb.pending_events.size() == 0)
            $display("midi_track_event_parser: match");
        else
            $display("midi_track_event_parser: mismatch");
        $finish;
    end

endmodule
